/* hw/rtl/evd_pkg.sv */
package evd_pkg;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int SLOT_W = 5;
	localparam int VAL_W = 32;
	localparam int MAG_W = 31;
	// Wide enough to hold any slot count up to 256.
	localparam int SLOT_CODE_W = 9;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [VAL_W:0] wide_t;
	typedef logic signed [VAL_W+1:0] wider_t;
	typedef logic [MAG_W-1:0] mag_t;

	localparam val_t VAL_MAX = val_t'({1'b0, {(VAL_W-1){1'b1}}});
	localparam val_t VAL_MIN = val_t'({1'b1, {(VAL_W-1){1'b0}}});
	localparam val_t ZERO_VAL = '0;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		val_t current_value;
		val_t turn_delta;
		val_t notch_center;
		mag_t capture_zone;
		mag_t hold_threshold;
		val_t lower_limit;
		val_t upper_limit;
	} turn_t;

	typedef struct packed {
		val_t new_value;
		logic latched;
	} result_t;

	typedef enum logic [1:0] {
		RES_NEXT    = 2'd0,
		RES_CENTER  = 2'd1,
		RES_RELEASE = 2'd2
	} res_kind_t;

	// Geometry of one turn, handed from the front pipeline to the hold stage.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		val_t delta;
		mag_t hold;
		val_t neg_hold;
		logic magnet;
		logic snap;
		logic far;
		val_t next_value;
		val_t center;
		wide_t center_minus_hold;
		wide_t center_plus_hold;
		val_t lower;
		val_t upper;
	} geo_t;

	// Outcome of the hold stage, handed to the release pipeline.
	typedef struct packed {
		res_kind_t kind;
		logic latched;
		val_t acc;
		val_t next_value;
		val_t center;
		wide_t center_minus_hold;
		wide_t center_plus_hold;
		val_t lower;
		val_t upper;
	} decision_t;

endpackage

/* hw/rtl/evd_stream_if.sv */
interface evd_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/encoder_virtual_detent.sv */
// Virtual detent for rotary encoder knobs.
// The turn channel takes one word per knob turn: slot, current value, delta,
// notch centre, capture zone, hold threshold and the two limits. The result
// channel returns one word per turn, the new value and the slot's hold flag.
// Both channels use a valid/ready handshake and a word moves on a rising edge
// where both are high.
// Throughput is one word per cycle while the result channel does not stall.
// It is set by the hold stage, which reads a slot's accumulator as a word
// enters and writes back the updated accumulator and flag as the word leaves;
// the last write is forwarded so turns on the same slot may follow back to
// back. A word accepted on the turn channel passes three geometry stages, the
// hold stage and two release stages before it reaches the result channel.
// Reset clears every hold flag and empties the pipeline. The accumulator
// memory needs no clearing, since an entry is only read while its slot is
// held, and every hold starts by writing zero.
// When the receiver stalls, the result stays put and bubbles in the pipeline
// close up; the turn channel drops ready once all six stages hold a word.
module encoder_virtual_detent #(
	parameter int SLOT_COUNT = evd_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	evd_stream_if.sink turn,
	evd_stream_if.source result
);
	import evd_pkg::*;

	// Geometry words from the front pipeline to the hold stage.
	evd_stream_if #(.payload_t(geo_t)) geo_ch ();
	// Hold decisions from the hold stage to the release pipeline.
	evd_stream_if #(.payload_t(decision_t)) dec_ch ();

	// Clamp, centre offsets, crossing and capture tests.
	evd_geom u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.turn(turn),
		.geo(geo_ch.source)
	);

	// Per-slot hold flags and accumulator memory.
	evd_hold #(.SLOT_COUNT(SLOT_COUNT)) u_hold (
		.clk(clk),
		.arst_n(arst_n),
		.geo(geo_ch.sink),
		.dec(dec_ch.source)
	);

	// Overshoot on release, final clamp and the output register.
	evd_release u_release (
		.clk(clk),
		.arst_n(arst_n),
		.dec(dec_ch.sink),
		.result(result)
	);

endmodule

/* hw/rtl/evd_geom.sv */
module evd_geom (
	input logic clk,
	input logic arst_n,
	evd_stream_if.sink turn,
	evd_stream_if.source geo
);
	import evd_pkg::*;

	// Stage 1 inputs.
	val_t cur_i, dlt_i, cen_i, lo_i, hi_i;
	mag_t hold_i;
	wide_t sum_i, dc_i, lc_i, hc_i, cmh_i, cph_i, nh_i;
	wider_t rel_i;

	// Stage registers.
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	turn_t item_s1, item_s2;
	wide_t sum_s1, dc_s1, lc_s1, hc_s1, cmh_s1, cph_s1;
	wider_t rel_s1;
	val_t nh_s1;
	logic magnet_s1;

	val_t next_s2, nh_s2;
	wide_t dn_s2, cmh_s2, cph_s2;
	logic [VAL_W-1:0] adc_s2;
	logic dcp_s2, dcn_s2, magnet_s2;

	geo_t geo_s3;

	// Stage 2 logic.
	logic lo_hit, hi_hit;
	val_t lo_s1v, hi_s1v, next_c;
	wide_t dn_c, dc_neg_c;
	logic [VAL_W-1:0] adc_c;
	logic dcp_c, dcn_c;

	// Stage 3 logic.
	wide_t dn_neg_c;
	logic [VAL_W-1:0] adn_c, zone_c;
	logic dnp_c, dnn_c, snap_c, far_c;
	geo_t geo_c;

	assign cur_i = turn.data.current_value;
	assign dlt_i = turn.data.turn_delta;
	assign cen_i = turn.data.notch_center;
	assign lo_i = turn.data.lower_limit;
	assign hi_i = turn.data.upper_limit;
	assign hold_i = turn.data.hold_threshold;

	assign sum_i = wide_t'(cur_i) + wide_t'(dlt_i);
	assign rel_i = wider_t'(cur_i) + wider_t'(dlt_i) - wider_t'(cen_i);
	assign dc_i = wide_t'(cur_i) - wide_t'(cen_i);
	assign lc_i = wide_t'(lo_i) - wide_t'(cen_i);
	assign hc_i = wide_t'(hi_i) - wide_t'(cen_i);
	assign cmh_i = wide_t'(cen_i) - wide_t'({2'b00, hold_i});
	assign cph_i = wide_t'(cen_i) + wide_t'({2'b00, hold_i});
	assign nh_i = -wide_t'({2'b00, hold_i});

	assign rdy_s3 = !v_s3 || geo.ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign turn.ready = rdy_s1;

	// The clamp is done on offsets from the centre so that the clamped offset
	// comes out of the same compare as the clamped value.
	assign lo_s1v = item_s1.lower_limit;
	assign hi_s1v = item_s1.upper_limit;
	assign lo_hit = rel_s1 < wider_t'(lc_s1);
	assign hi_hit = rel_s1 > wider_t'(hc_s1);
	assign next_c = lo_hit ? lo_s1v : (hi_hit ? hi_s1v : sum_s1[VAL_W-1:0]);
	assign dn_c = lo_hit ? lc_s1 : (hi_hit ? hc_s1 : rel_s1[VAL_W:0]);
	assign dc_neg_c = -dc_s1;
	assign adc_c = dc_s1[VAL_W] ? dc_neg_c[VAL_W-1:0] : dc_s1[VAL_W-1:0];
	assign dcn_c = dc_s1[VAL_W];
	assign dcp_c = !dc_s1[VAL_W] && (dc_s1 != '0);

	assign dn_neg_c = -dn_s2;
	assign adn_c = dn_s2[VAL_W] ? dn_neg_c[VAL_W-1:0] : dn_s2[VAL_W-1:0];
	assign dnn_c = dn_s2[VAL_W];
	assign dnp_c = !dn_s2[VAL_W] && (dn_s2 != '0);
	assign zone_c = {1'b0, item_s2.capture_zone};
	assign snap_c = (dcp_s2 && dnn_c) || (dcn_s2 && dnp_c) ||
		(adn_c <= zone_c && adn_c < adc_s2);
	assign far_c = adc_s2 > zone_c;

	always_comb begin
		geo_c.slot = item_s2.slot;
		geo_c.delta = item_s2.turn_delta;
		geo_c.hold = item_s2.hold_threshold;
		geo_c.neg_hold = nh_s2;
		geo_c.magnet = magnet_s2;
		geo_c.snap = snap_c;
		geo_c.far = far_c;
		geo_c.next_value = next_s2;
		geo_c.center = item_s2.notch_center;
		geo_c.center_minus_hold = cmh_s2;
		geo_c.center_plus_hold = cph_s2;
		geo_c.lower = item_s2.lower_limit;
		geo_c.upper = item_s2.upper_limit;
	end

	assign geo.valid = v_s3;
	assign geo.data = geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= turn.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && turn.valid) begin
			item_s1 <= turn.data;
			sum_s1 <= sum_i;
			rel_s1 <= rel_i;
			dc_s1 <= dc_i;
			lc_s1 <= lc_i;
			hc_s1 <= hc_i;
			cmh_s1 <= cmh_i;
			cph_s1 <= cph_i;
			nh_s1 <= nh_i[VAL_W-1:0];
			magnet_s1 <= (hold_i == '0);
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1;
			next_s2 <= next_c;
			dn_s2 <= dn_c;
			adc_s2 <= adc_c;
			dcp_s2 <= dcp_c;
			dcn_s2 <= dcn_c;
			cmh_s2 <= cmh_s1;
			cph_s2 <= cph_s1;
			nh_s2 <= nh_s1;
			magnet_s2 <= magnet_s1;
		end
		if (rdy_s3 && v_s2) begin
			geo_s3 <= geo_c;
		end
	end

endmodule

/* hw/rtl/evd_hold.sv */
module evd_hold #(
	parameter int SLOT_COUNT = evd_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	evd_stream_if.sink geo,
	evd_stream_if.source dec
);
	import evd_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [SLOT_CODE_W-1:0] slot_code;
	logic [IDX_W-1:0] idx_in, idx_s4;
	logic load, advance, wen;
	logic v_s4;
	geo_t geo_s4;

	val_t acc_mem [SLOT_COUNT];
	val_t rdata_s4;
	logic [SLOT_COUNT-1:0] flag_q;

	logic fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	val_t fwd_data_q;

	val_t acc_rd, delta, neg_hold, acc_sat, wdata;
	wide_t acc_sum;
	mag_t hold;
	logic flag, held, reach, rel, keep, new_flag;
	res_kind_t kind;
	decision_t dec_c;

	// Slots beyond the table fall back to slot zero.
	assign slot_code = SLOT_CODE_W'(geo.data.slot);
	assign idx_in = (slot_code < SLOT_CODE_W'(SLOT_COUNT)) ? slot_code[IDX_W-1:0] : '0;

	assign geo.ready = !v_s4 || dec.ready;
	assign load = geo.valid && geo.ready;
	assign advance = v_s4 && dec.ready;
	assign wen = advance && !geo_s4.magnet;

	assign delta = geo_s4.delta;
	assign neg_hold = geo_s4.neg_hold;
	assign hold = geo_s4.hold;

	// The word just written may be the one this word read before that write landed.
	assign acc_rd = (fwd_valid_q && fwd_idx_q == idx_s4) ? fwd_data_q : rdata_s4;
	assign acc_sum = wide_t'(acc_rd) + wide_t'(delta);
	assign acc_sat = (acc_sum[VAL_W] != acc_sum[VAL_W-1]) ?
		(acc_sum[VAL_W] ? VAL_MIN : VAL_MAX) : acc_sum[VAL_W-1:0];
	// Saturation never changes which side of the threshold the sum lies on.
	assign reach = (acc_sum >= wide_t'({2'b00, hold})) || (acc_sum <= wide_t'(neg_hold));

	assign flag = flag_q[idx_s4];
	assign held = flag && !geo_s4.far;
	assign rel = held && reach;
	assign keep = held && !rel;

	always_comb begin
		if (geo_s4.magnet) begin
			new_flag = flag;
			kind = geo_s4.snap ? RES_CENTER : RES_NEXT;
		end else if (held) begin
			new_flag = !rel;
			kind = rel ? RES_RELEASE : RES_CENTER;
		end else begin
			new_flag = geo_s4.snap;
			kind = geo_s4.snap ? RES_CENTER : RES_NEXT;
		end
	end

	assign wdata = keep ? acc_sat : ZERO_VAL;

	always_comb begin
		dec_c.kind = kind;
		dec_c.latched = new_flag;
		dec_c.acc = acc_sat;
		dec_c.next_value = geo_s4.next_value;
		dec_c.center = geo_s4.center;
		dec_c.center_minus_hold = geo_s4.center_minus_hold;
		dec_c.center_plus_hold = geo_s4.center_plus_hold;
		dec_c.lower = geo_s4.lower;
		dec_c.upper = geo_s4.upper;
	end

	assign dec.valid = v_s4;
	assign dec.data = dec_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			flag_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (geo.ready) v_s4 <= geo.valid;
			if (wen) begin
				flag_q[idx_s4] <= new_flag;
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			geo_s4 <= geo.data;
			idx_s4 <= idx_in;
		end
		if (wen) begin
			fwd_idx_q <= idx_s4;
			fwd_data_q <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) acc_mem[idx_s4] <= wdata;
		if (load) rdata_s4 <= acc_mem[idx_in];
	end

endmodule

/* hw/rtl/evd_release.sv */
module evd_release (
	input logic clk,
	input logic arst_n,
	evd_stream_if.sink dec,
	evd_stream_if.source result
);
	import evd_pkg::*;

	logic v_s5, v_s6;
	logic rdy_s5, rdy_s6;
	decision_t dec_s5;
	wider_t rv_c, rv_s5;
	val_t acc_c, lo_c, hi_c, center_c, next_c, value_c;
	wide_t cmh_c, cph_c;
	val_t new_value_s6;
	logic latched_s6;

	assign rdy_s6 = !v_s6 || result.ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign dec.ready = rdy_s5;

	// Release lands at the centre plus the overshoot past the threshold.
	assign acc_c = dec.data.acc;
	assign cmh_c = dec.data.center_minus_hold;
	assign cph_c = dec.data.center_plus_hold;
	assign rv_c = (acc_c > ZERO_VAL) ? (wider_t'(acc_c) + wider_t'(cmh_c)) :
		(wider_t'(acc_c) + wider_t'(cph_c));

	assign lo_c = dec_s5.lower;
	assign hi_c = dec_s5.upper;
	assign center_c = dec_s5.center;
	assign next_c = dec_s5.next_value;

	always_comb begin
		case (dec_s5.kind)
			RES_CENTER: value_c = center_c;
			RES_RELEASE: begin
				if (rv_s5 < wider_t'(lo_c)) value_c = lo_c;
				else if (rv_s5 > wider_t'(hi_c)) value_c = hi_c;
				else value_c = rv_s5[VAL_W-1:0];
			end
			RES_NEXT: value_c = next_c;
			default: value_c = next_c;
		endcase
	end

	assign result.valid = v_s6;
	assign result.data.new_value = new_value_s6;
	assign result.data.latched = latched_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= dec.valid;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && dec.valid) begin
			dec_s5 <= dec.data;
			rv_s5 <= rv_c;
		end
		if (rdy_s6 && v_s5) begin
			new_value_s6 <= value_c;
			latched_s6 <= dec_s5.latched;
		end
	end

endmodule
